// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of aclk outside reset.
`define U8U2_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a plain condition on every rising edge of aclk outside reset.
`define U8U2_ASSERT_TRUE(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

`endif

// ===== rtl/u8u2_pkg.sv =====
package u8u2_pkg;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int PARTIAL_W = 10;

    localparam logic [STATUS_W-1:0] ST_CHAR  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END   = 2'd2;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] ASCII_BITS = 8'h7F;

    typedef struct packed {
        logic                 err;
        logic [1:0]           pending;
        logic [PARTIAL_W-1:0] partial;
    } u8u2_state_t;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
        logic                eos;
    } u8u2_result_t;

endpackage

// ===== rtl/u8u2_decode.sv =====
module u8u2_decode (
    input  u8u2_pkg::u8u2_state_t   state_cur,
    input  logic [7:0]              byte_in,
    input  logic                    last_byte,
    output u8u2_pkg::u8u2_state_t   state_nxt,
    output u8u2_pkg::u8u2_result_t  result
);
    import u8u2_pkg::*;

    logic [CODE_W-1:0] merged;
    logic [1:0]        pend_dec;
    logic              is_cont;

    assign merged   = {state_cur.partial, byte_in[5:0] & CONT_BITS[5:0]};
    assign pend_dec = state_cur.pending - 2'd1;
    assign is_cont  = (byte_in & CONT_MASK) == CONT_TAG;

    always_comb begin
        state_nxt     = state_cur;
        result.valid  = 1'b0;
        result.code   = '0;
        result.status = ST_CHAR;
        result.eos    = last_byte;

        if (state_cur.err) begin
            if (last_byte) begin
                result.valid  = 1'b1;
                result.status = ST_END;
            end
        end else if (state_cur.pending != 2'd0) begin
            if (!is_cont) begin
                result.valid  = 1'b1;
                result.status = ST_ERROR;
                state_nxt.err = 1'b1;
            end else if (pend_dec == 2'd0) begin
                result.valid      = 1'b1;
                result.code       = merged;
                state_nxt.pending = 2'd0;
                state_nxt.partial = '0;
            end else begin
                state_nxt.pending = pend_dec;
                state_nxt.partial = merged[PARTIAL_W-1:0];
                if (last_byte) begin
                    result.valid  = 1'b1;
                    result.status = ST_ERROR;
                end
            end
        end else if (!byte_in[7]) begin
            result.valid = 1'b1;
            result.code  = {8'h00, byte_in & ASCII_BITS};
        end else if ((byte_in & LEAD2_MASK) == LEAD2_TAG) begin
            state_nxt.pending = 2'd1;
            state_nxt.partial = {2'b00, byte_in & LEAD2_BITS};
            result.valid      = last_byte;
            result.status     = last_byte ? ST_ERROR : ST_CHAR;
        end else if ((byte_in & LEAD3_MASK) == LEAD3_TAG) begin
            state_nxt.pending = 2'd2;
            state_nxt.partial = {2'b00, byte_in & LEAD3_BITS};
            result.valid      = last_byte;
            result.status     = last_byte ? ST_ERROR : ST_CHAR;
        end else begin
            result.valid  = 1'b1;
            result.status = ST_ERROR;
            state_nxt.err = 1'b1;
        end

        if (state_nxt.err) begin
            state_nxt.pending = 2'd0;
            state_nxt.partial = '0;
        end
        if (last_byte) begin
            state_nxt = '0;
        end
    end

endmodule

// ===== rtl/utf8_to_ucs2_decoder.sv =====
// Decodes a stream of UTF-8 bytes, one byte per transaction, into 16-bit UCS-2
// code units; s_last_byte marks the byte that ends a string. Each byte passes
// an input register, one short decode step against the held sequence state,
// and a result register; a byte is taken every cycle unless the result register
// is full, m_ready is low and the byte gives a result. Lead bytes that start a
// sequence, unless they end the string, and discarded bytes after an error give
// no result. A string's first error gives status 1 once, the rest is dropped,
// and a later last byte gives an end marker with status 2. m_code_unit is zero
// unless m_status is 0; m_end_of_string is set on the result closing a string.
`include "assert_macros.svh"

module utf8_to_ucs2_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic [1:0]  m_status,
    output logic        m_end_of_string
);
    import u8u2_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    u8u2_state_t  state_reg;
    u8u2_state_t  state_next;
    u8u2_result_t result;
    logic         out_valid_reg;
    logic [15:0]  out_code_reg;
    logic [1:0]   out_status_reg;
    logic         out_eos_reg;
    logic         advance;

    u8u2_decode u_decode (
        .state_cur (state_reg),
        .byte_in   (in_byte_reg),
        .last_byte (in_last_reg),
        .state_nxt (state_next),
        .result    (result)
    );

    // A transaction that gives no result may leave even while the result register is full.
    assign advance = in_valid_reg && (!result.valid || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && result.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_in;
            in_last_reg <= s_last_byte;
        end
        if (advance && result.valid) begin
            out_code_reg   <= result.code;
            out_status_reg <= result.status;
            out_eos_reg    <= result.eos;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_code_unit     = out_code_reg;
    assign m_status        = out_status_reg;
    assign m_end_of_string = out_eos_reg;

    `U8U2_ASSERT_CLK(a_code_zero, m_valid && m_status != ST_CHAR |-> m_code_unit == '0, "code set")
    `U8U2_ASSERT_CLK(a_end_closes, m_valid && m_status == ST_END |-> m_end_of_string, "end open")
    `U8U2_ASSERT_CLK(a_err_idle, state_reg.err |-> state_reg.pending == '0, "pending after error")
    `U8U2_ASSERT_CLK(a_end_clears, advance && in_last_reg |=> state_reg == '0, "state kept at end")

endmodule
